[rtl/core/srru_pkg.sv]
// Shared constants, types and state codes of the streaming RRIP replacement unit.
`timescale 1ns / 1ps

package srru_pkg;

  // Geometry of the cache and of the signature table.
  localparam int unsigned NUM_SETS    = 2048;
  localparam int unsigned NUM_WAYS    = 16;
  localparam int unsigned SIG_BITS    = 6;
  localparam int unsigned ADDR_BITS   = 48;

  localparam int unsigned SET_W       = $clog2(NUM_SETS);
  localparam int unsigned WAY_W       = $clog2(NUM_WAYS);
  localparam int unsigned SIG_ENTRIES = 1 << SIG_BITS;

  // Field widths fixed by the interface.
  localparam int unsigned SET_IN_W    = 11;
  localparam int unsigned WAY_IN_W    = 4;
  localparam int unsigned MASK_W      = 16;
  localparam int unsigned PC_W        = 48;

  // The clearing pass covers the larger of the two indexed stores.
  localparam int unsigned CLR_DEPTH   = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
  localparam int unsigned CLR_W       = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  // Re-reference and counter values.
  localparam logic [1:0] RRPV_DISTANT = 2'd3;
  localparam logic [1:0] RRPV_NEAR    = 2'd0;
  localparam logic [1:0] CNT_MAX      = 2'd3;
  localparam logic [1:0] REUSE_INIT   = 2'd1;
  localparam logic [1:0] REUSE_THRESH = 2'd2;
  localparam logic [1:0] STREAM_THRESH = 2'd2;

  // Strides, in bytes, that count as streaming.
  localparam int unsigned STRIDE_NEAR = 64;
  localparam int unsigned STRIDE_FAR  = 128;

  typedef logic [NUM_WAYS-1:0][1:0]          rrpv_row_t;
  typedef logic [NUM_WAYS-1:0][SIG_BITS-1:0] sig_row_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] prev_addr;
    logic [1:0]           score;
  } hist_t;

  // Row write into the per-set memories.
  typedef struct packed {
    logic             we;
    logic [SET_W-1:0] set;
    rrpv_row_t        rrpv;
    sig_row_t         sig;
    hist_t            hist;
  } set_wr_t;

  // Single entry write into the signature reuse table.
  typedef struct packed {
    logic                we;
    logic [SIG_BITS-1:0] addr;
    logic [1:0]          data;
  } reuse_wr_t;

  // Outcome of the victim search over one set.
  typedef struct packed {
    logic [WAY_W-1:0] way;
    logic             age_we;
    rrpv_row_t        aged;
  } victim_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_e;

  typedef enum logic {
    OP_VICTIM = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

endpackage

[rtl/core/ship_rrip_streaming_replacement_unit.sv]
// Top level: sequencer and datapath of the streaming RRIP replacement unit.
// A victim request is accepted, reads its set row with busy high and strobes done_o in the
// cycle after the read.
// An update keeps busy high through the set row read and then the reuse counter read, and
// strobes done_o in the cycle after the counter read. The receiver cannot stall the result strobe.
// After reset a clearing pass writes the reset values into every set and signature entry with busy high.
`timescale 1ns / 1ps

module ship_rrip_streaming_replacement_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [srru_pkg::SET_IN_W-1:0] set_index_i,
  input  logic [srru_pkg::WAY_IN_W-1:0] way_index_i,
  input  logic [srru_pkg::MASK_W-1:0]   valid_mask_i,
  input  logic [srru_pkg::ADDR_BITS-1:0] phys_addr_i,
  input  logic [srru_pkg::PC_W-1:0]     prog_counter_i,
  input  logic                          was_hit_i,
  output logic                          done_o,
  output logic [3:0]                    victim_way_o,
  output logic [1:0]                    new_rrpv_o,
  output logic                          set_streaming_o
);
  import srru_pkg::*;

  localparam int unsigned DIFF_W = ADDR_BITS + 1;
  localparam logic [DIFF_W-1:0] D_NEAR = DIFF_W'(STRIDE_NEAR);
  localparam logic [DIFF_W-1:0] D_FAR  = DIFF_W'(STRIDE_FAR);

  state_e state_q, state_d;
  logic [CLR_W-1:0] clr_cnt_q, clr_cnt_d;

  // Captured item.
  op_e                  op_q;
  logic [SET_W-1:0]     set_q;
  logic [WAY_W-1:0]     way_q;
  logic [MASK_W-1:0]    mask_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [SIG_BITS-1:0]  sig_q;
  logic                 hit_q;

  // Result registers.
  logic       done_q, done_d;
  logic [3:0] victim_q, victim_d;
  logic [1:0] rrpv_q, rrpv_d;
  logic       stream_q, stream_d;

  logic accept;

  set_wr_t    set_wr;
  reuse_wr_t  reuse_wr;
  rrpv_row_t  rrpv_row;
  sig_row_t   sig_row;
  hist_t      hist;
  logic       reuse_rd_en;
  logic [SIG_BITS-1:0] old_sig;
  logic [1:0] reuse_old;
  logic [1:0] reuse_new;
  victim_t    victim;

  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign old_sig = sig_row[way_q];

  srru_set_store u_set_store (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_set_i   (set_index_i[SET_W-1:0]),
    .wr_i       (set_wr),
    .rrpv_row_o (rrpv_row),
    .sig_row_o  (sig_row),
    .hist_o     (hist)
  );

  srru_reuse_table u_reuse_table (
    .clk_i       (clk_i),
    .rd_en_i     (reuse_rd_en),
    .rd_addr_a_i (old_sig),
    .rd_addr_b_i (sig_q),
    .wr_i        (reuse_wr),
    .rd_data_a_o (reuse_old),
    .rd_data_b_o (reuse_new)
  );

  srru_victim_sel u_victim_sel (
    .valid_mask_i (mask_q),
    .rrpv_row_i   (rrpv_row),
    .victim_o     (victim)
  );

  // Stride test and update arithmetic, used in the write cycle of an update.
  logic [DIFF_W-1:0] diff;
  logic              stride_hit;
  logic [1:0]        score_next;
  logic [1:0]        reuse_dec;
  logic [1:0]        reuse_inc;
  logic [1:0]        reuse_sig_val;
  logic [1:0]        ins_rrpv;
  rrpv_row_t         rrpv_upd;
  sig_row_t          sig_upd;

  always_comb begin
    diff = {1'b0, addr_q} - {1'b0, hist.prev_addr};
    stride_hit = (diff == D_NEAR) || (diff == D_FAR) ||
                 (diff == -D_NEAR) || (diff == -D_FAR);
    if (hist.prev_addr == '0) begin
      score_next = 2'd0;
    end else if (stride_hit) begin
      score_next = (hist.score == CNT_MAX) ? hist.score : hist.score + 2'd1;
    end else begin
      score_next = (hist.score == 2'd0) ? hist.score : hist.score - 2'd1;
    end

    reuse_inc = (reuse_new == CNT_MAX) ? reuse_new : reuse_new + 2'd1;
    reuse_dec = (reuse_old == 2'd0) ? reuse_old : reuse_old - 2'd1;
    // The incoming signature sees the penalty when it matches the evicted one.
    reuse_sig_val = (old_sig == sig_q) ? reuse_dec : reuse_new;
    ins_rrpv = hit_q ? RRPV_NEAR :
               ((reuse_sig_val >= REUSE_THRESH) ? RRPV_NEAR : RRPV_DISTANT);

    rrpv_upd        = rrpv_row;
    rrpv_upd[way_q] = ins_rrpv;
    sig_upd         = sig_row;
    sig_upd[way_q]  = sig_q;
  end

  // Sequencer: clearing pass, accept, row read, counter read and write back.
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    done_d      = 1'b0;
    victim_d    = victim_q;
    rrpv_d      = rrpv_q;
    stream_d    = stream_q;
    reuse_rd_en = 1'b0;

    set_wr      = '0;
    set_wr.set  = set_q;
    set_wr.rrpv = rrpv_row;
    set_wr.sig  = sig_row;
    set_wr.hist = hist;
    reuse_wr    = '0;

    unique case (state_q)
      ST_CLEAR: begin
        if ({1'b0, clr_cnt_q} < (CLR_W + 1)'(NUM_SETS)) begin
          set_wr.we             = 1'b1;
          set_wr.set            = clr_cnt_q[SET_W-1:0];
          set_wr.rrpv           = {NUM_WAYS{RRPV_DISTANT}};
          set_wr.sig            = '0;
          set_wr.hist.prev_addr = '0;
          set_wr.hist.score     = 2'd0;
        end
        if ({1'b0, clr_cnt_q} < (CLR_W + 1)'(SIG_ENTRIES)) begin
          reuse_wr.we   = 1'b1;
          reuse_wr.addr = clr_cnt_q[SIG_BITS-1:0];
          reuse_wr.data = REUSE_INIT;
        end
        if (clr_cnt_q == CLR_W'(CLR_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + CLR_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (op_q == OP_VICTIM) begin
          set_wr.we   = victim.age_we;
          set_wr.rrpv = victim.aged;
          done_d      = 1'b1;
          victim_d    = 4'(victim.way);
          rrpv_d      = 2'd0;
          stream_d    = (hist.score >= STREAM_THRESH);
          state_d     = ST_IDLE;
        end else begin
          reuse_rd_en = 1'b1;
          state_d     = ST_WRITE;
        end
      end
      ST_WRITE: begin
        set_wr.we             = 1'b1;
        set_wr.rrpv           = rrpv_upd;
        set_wr.sig            = sig_upd;
        set_wr.hist.prev_addr = addr_q;
        set_wr.hist.score     = score_next;
        reuse_wr.we           = 1'b1;
        reuse_wr.addr         = hit_q ? sig_q : old_sig;
        reuse_wr.data         = hit_q ? reuse_inc : reuse_dec;
        done_d                = 1'b1;
        victim_d              = 4'd0;
        rrpv_d                = ins_rrpv;
        stream_d              = (score_next >= STREAM_THRESH);
        state_d               = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= done_d;
    end
  end

  // Item capture and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(op_i);
      set_q  <= set_index_i[SET_W-1:0];
      way_q  <= way_index_i[WAY_W-1:0];
      mask_q <= valid_mask_i;
      addr_q <= phys_addr_i;
      sig_q  <= prog_counter_i[SIG_BITS+1:2];
      hit_q  <= was_hit_i;
    end
    victim_q <= victim_d;
    rrpv_q   <= rrpv_d;
    stream_q <= stream_d;
  end

  assign done_o          = done_q;
  assign victim_way_o    = victim_q;
  assign new_rrpv_o      = rrpv_q;
  assign set_streaming_o = stream_q;

endmodule

[rtl/core/srru_set_store.sv]
// Per-set memories: packed re-reference row, signature row and stride history.
`timescale 1ns / 1ps

module srru_set_store (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [srru_pkg::SET_W-1:0]  rd_set_i,
  input  srru_pkg::set_wr_t           wr_i,
  output srru_pkg::rrpv_row_t         rrpv_row_o,
  output srru_pkg::sig_row_t          sig_row_o,
  output srru_pkg::hist_t             hist_o
);
  import srru_pkg::*;

  rrpv_row_t rrpv_mem [NUM_SETS];
  sig_row_t  sig_mem  [NUM_SETS];
  hist_t     hist_mem [NUM_SETS];

  rrpv_row_t rrpv_rd_q;
  sig_row_t  sig_rd_q;
  hist_t     hist_rd_q;

  // Whole rows are written together; read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      rrpv_mem[wr_i.set] <= wr_i.rrpv;
      sig_mem[wr_i.set]  <= wr_i.sig;
      hist_mem[wr_i.set] <= wr_i.hist;
    end
    if (rd_en_i) begin
      rrpv_rd_q <= rrpv_mem[rd_set_i];
      sig_rd_q  <= sig_mem[rd_set_i];
      hist_rd_q <= hist_mem[rd_set_i];
    end
  end

  assign rrpv_row_o = rrpv_rd_q;
  assign sig_row_o  = sig_rd_q;
  assign hist_o     = hist_rd_q;

endmodule

[rtl/core/srru_reuse_table.sv]
// Signature reuse counters: one write port and two registered read ports.
`timescale 1ns / 1ps

module srru_reuse_table (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [srru_pkg::SIG_BITS-1:0] rd_addr_a_i,
  input  logic [srru_pkg::SIG_BITS-1:0] rd_addr_b_i,
  input  srru_pkg::reuse_wr_t           wr_i,
  output logic [1:0]                    rd_data_a_o,
  output logic [1:0]                    rd_data_b_o
);
  import srru_pkg::*;

  logic [1:0] reuse_mem [SIG_ENTRIES];
  logic [1:0] rd_a_q;
  logic [1:0] rd_b_q;

  // Port A serves the evicted line's signature, port B the incoming one.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      reuse_mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_a_q <= reuse_mem[rd_addr_a_i];
      rd_b_q <= reuse_mem[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

[rtl/core/srru_victim_sel.sv]
// Victim search: first invalid way, otherwise ageing of the set and first distant way.
`timescale 1ns / 1ps

module srru_victim_sel (
  input  logic [srru_pkg::MASK_W-1:0] valid_mask_i,
  input  srru_pkg::rrpv_row_t         rrpv_row_i,
  output srru_pkg::victim_t           victim_o
);
  import srru_pkg::*;

  logic [NUM_WAYS-1:0] way_valid;

  // Ways beyond the mask count as valid.
  if (NUM_WAYS <= MASK_W) begin : g_narrow
    assign way_valid = valid_mask_i[NUM_WAYS-1:0];
  end else begin : g_wide
    assign way_valid = {{(NUM_WAYS - MASK_W){1'b1}}, valid_mask_i};
  end

  logic             any_invalid;
  logic [WAY_W-1:0] first_invalid;
  logic [WAY_W-1:0] first_top;
  logic [1:0]       top;
  logic [1:0]       add;
  logic [NUM_WAYS-1:0] has_hi;
  logic [NUM_WAYS-1:0] has_lo;
  logic [NUM_WAYS-1:0] is_top;

  // True when any way of the row has its upper bit set.
  function automatic logic has_hi_all(input rrpv_row_t row);
    logic r;
    r = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      r = r | row[w][1];
    end
    return r;
  endfunction

  always_comb begin
    any_invalid   = 1'b0;
    first_invalid = '0;
    first_top     = '0;
    // Lowest invalid way wins, so scan from the top down.
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (!way_valid[w]) begin
        any_invalid   = 1'b1;
        first_invalid = WAY_W'(w);
      end
    end

    // The largest value in the set, built from bit reductions.
    for (int w = 0; w < NUM_WAYS; w++) begin
      has_hi[w] = rrpv_row_i[w][1];
      has_lo[w] = rrpv_row_i[w][0] & (rrpv_row_i[w][1] == (|has_hi_all(rrpv_row_i)));
    end
    top[1] = |has_hi;
    top[0] = |has_lo;
    add    = RRPV_DISTANT - top;

    // After ageing, the ways that held the maximum are the ones at the distant value.
    for (int w = 0; w < NUM_WAYS; w++) begin
      is_top[w] = (rrpv_row_i[w] == top);
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (is_top[w]) begin
        first_top = WAY_W'(w);
      end
    end

    for (int w = 0; w < NUM_WAYS; w++) begin
      victim_o.aged[w] = rrpv_row_i[w] + add;
    end
    victim_o.age_we = !any_invalid && (top != RRPV_DISTANT);
    victim_o.way    = any_invalid ? first_invalid : first_top;
  end

endmodule
